// ===== hdl/twfn_pkg.sv =====
`default_nettype none

package twfn_pkg;

	localparam int SINE_DEPTH = 256;
	localparam int SINE_IDX_W = $clog2(SINE_DEPTH);
	localparam int PHASE_W = 32;
	localparam int MAX_CHANNELS = 8;
	localparam int CHAN_W = $clog2(MAX_CHANNELS);
	localparam int CNT_CFG_W = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FLUTTER_STEP = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WOW_STEP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FLUTTER_DEPTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WOW_DEPTH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NOISE_LEVEL = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_NOISE_SEED = 3'd6;

	localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;
	localparam logic [17:0] UNITY_GAIN = 18'h10000;
	localparam logic [17:0] GAIN_MAX = 18'h3FFFF;

	localparam int GAIN_ITERS = 16;
	localparam int MUL_ITERS = 18;
	localparam int ITER_W = 5;

	typedef struct packed {
		logic signed [15:0] sample_in;
		logic block_end;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] sample_out;
		logic clipped;
		logic block_end_out;
	} out_item_t;

	typedef logic [SINE_DEPTH-1:0][15:0] sine_rom_t;

	function automatic longint quarter_sine(input longint t);
		longint t2;
		longint p;
		t2 = (t * t) >>> 16;
		p = 42334 - ((t2 * 5223) >>> 16);
		p = 102944 - ((t2 * p) >>> 16);
		return (t * p) >>> 16;
	endfunction

	function automatic sine_rom_t build_sine();
		sine_rom_t rom;
		longint q;
		longint quadrant;
		longint t;
		longint s;
		for (int i = 0; i < SINE_DEPTH; i++) begin
			q = longint'(i) * 4;
			quadrant = (q / SINE_DEPTH) % 4;
			t = ((q % SINE_DEPTH) * 65536) / SINE_DEPTH;
			if ((quadrant % 2) == 1)
				t = 65536 - t;
			s = quarter_sine(t) >>> 1;
			if (s > 32767)
				s = 32767;
			if (quadrant >= 2)
				s = -s;
			rom[i] = s[15:0];
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine();

endpackage

`default_nettype wire

// ===== hdl/tape_wow_flutter_noise.sv =====
// Wow and flutter gain modulation with additive noise for interleaved 16-bit audio.
// Input channel: in_valid, in_stall and in_data carry one sample request; it is
// taken at an edge where in_valid is high and in_stall is low. Output channel:
// out_valid, out_stall and out_data carry one result per sample in order.
// Configuration: cfg_valid, cfg_ready, cfg_index and cfg_data write one register
// per edge; cfg_ready is always high and writes are meant for an idle block.
// Each sample goes through a shift-and-add multiplier that retires one bit of
// the multiplier operand per cycle. A sample that opens a frame first forms the
// frame gain from two sine lookups in one multiply pass and a sum step, then
// every sample runs a multiply pass for its gain and noise products and a step
// for rounding and saturation. The block takes no new request while a sample
// is being worked on; it takes one in the cycle after the result is written.
// A finished result waits in the output register while out_stall is high; the
// next sample may be accepted and worked on meanwhile, and its result waits in
// the last step until the register is free.
// Reset restores the documented register values, clears both phases, the channel
// index and the output valid, sets unity gain and loads the noise generator with 1.
`default_nettype none

module tape_wow_flutter_noise (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  twfn_pkg::in_item_t                in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output twfn_pkg::out_item_t               out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [twfn_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [twfn_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import twfn_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_GAIN = 3'd1;
	localparam logic [2:0] ST_GSUM = 3'd2;
	localparam logic [2:0] ST_MUL = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [CNT_CFG_W-1:0] chan_cnt_q;
	logic [PHASE_W-1:0] fstep_q;
	logic [PHASE_W-1:0] wstep_q;
	logic [15:0] fdepth_q;
	logic [15:0] wdepth_q;
	logic [15:0] nlevel_q;

	logic [PHASE_W-1:0] fphase_q;
	logic [PHASE_W-1:0] wphase_q;
	logic [CHAN_W-1:0] chan_idx_q;
	logic [17:0] gain_q;
	logic [31:0] lfsr_q;

	logic [2:0] state_q;
	logic [ITER_W-1:0] iter_q;
	logic [34:0] ma_q;
	logic [17:0] qa_q;
	logic [34:0] acca_q;
	logic [32:0] mb_q;
	logic [17:0] qb_q;
	logic [32:0] accb_q;
	logic [15:0] x_q;
	logic [15:0] noise_q;
	logic bend_q;

	out_item_t out_q;
	logic out_valid_q;

	logic in_acc;
	logic cfg_acc;
	logic [CNT_CFG_W-1:0] cnt_eff;
	logic frame_end;
	logic [31:0] lfsr_next;
	logic [15:0] noise_next;
	logic [15:0] sin_f;
	logic [15:0] sin_w;
	logic [19:0] gsum;
	logic [17:0] gain_new;
	logic [34:0] msum;
	logic [19:0] y;
	logic clip_hi;
	logic clip_lo;
	logic out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign cfg_acc = cfg_valid && cfg_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		if (chan_cnt_q == '0)
			cnt_eff = CNT_CFG_W'(1);
		else if (chan_cnt_q > CNT_CFG_W'(MAX_CHANNELS))
			cnt_eff = CNT_CFG_W'(MAX_CHANNELS);
		else
			cnt_eff = chan_cnt_q;
		frame_end = ({{(CNT_CFG_W-CHAN_W){1'b0}}, chan_idx_q} + CNT_CFG_W'(1)) >= cnt_eff;

		lfsr_next = (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_TAPS : 32'h0);
		noise_next = {~lfsr_next[31], lfsr_next[30:16]};

		sin_f = SINE_ROM[fphase_q[PHASE_W-1 -: SINE_IDX_W]];
		sin_w = SINE_ROM[wphase_q[PHASE_W-1 -: SINE_IDX_W]];

		gsum = 20'h10000 + acca_q[34:15] + {{2{accb_q[32]}}, accb_q[32:15]};
		if (gsum[19])
			gain_new = '0;
		else if (gsum[18])
			gain_new = GAIN_MAX;
		else
			gain_new = gsum[17:0];

		msum = acca_q + 35'h8000;
		y = {msum[34], msum[34:16]} + {{3{accb_q[32]}}, accb_q[32:16]};
		clip_hi = !y[19] && (y[18:15] != 4'h0);
		clip_lo = y[19] && (y[18:15] != 4'hF);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_cnt_q <= CNT_CFG_W'(1);
			fstep_q <= PHASE_W'(486958);
			wstep_q <= PHASE_W'(48696);
			fdepth_q <= 16'd197;
			wdepth_q <= 16'd131;
			nlevel_q <= 16'd328;
			fphase_q <= '0;
			wphase_q <= '0;
			chan_idx_q <= '0;
			gain_q <= UNITY_GAIN;
			lfsr_q <= 32'd1;
			state_q <= ST_IDLE;
			iter_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						lfsr_q <= lfsr_next;
						iter_q <= '0;
						if (frame_end) begin
							fphase_q <= fphase_q + fstep_q;
							wphase_q <= wphase_q + wstep_q;
							chan_idx_q <= '0;
						end else begin
							chan_idx_q <= chan_idx_q + CHAN_W'(1);
						end
						state_q <= (chan_idx_q == '0) ? ST_GAIN : ST_MUL;
					end
				end
				ST_GAIN: begin
					iter_q <= iter_q + ITER_W'(1);
					if (iter_q == ITER_W'(GAIN_ITERS - 1))
						state_q <= ST_GSUM;
				end
				ST_GSUM: begin
					gain_q <= gain_new;
					iter_q <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					iter_q <= iter_q + ITER_W'(1);
					if (iter_q == ITER_W'(MUL_ITERS - 1))
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (cfg_acc) begin
				case (cfg_index)
					REG_CHANNEL_COUNT: chan_cnt_q <= cfg_data[CNT_CFG_W-1:0];
					REG_FLUTTER_STEP: fstep_q <= cfg_data[PHASE_W-1:0];
					REG_WOW_STEP: wstep_q <= cfg_data[PHASE_W-1:0];
					REG_FLUTTER_DEPTH: fdepth_q <= cfg_data[15:0];
					REG_WOW_DEPTH: wdepth_q <= cfg_data[15:0];
					REG_NOISE_LEVEL: nlevel_q <= cfg_data[15:0];
					REG_NOISE_SEED: lfsr_q <= (cfg_data == '0) ? 32'd1 : cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					x_q <= in_data.sample_in;
					noise_q <= noise_next;
					bend_q <= in_data.block_end;
					if (chan_idx_q == '0) begin
						ma_q <= {{19{sin_f[15]}}, sin_f};
						qa_q <= {2'b00, fdepth_q};
						mb_q <= {{17{sin_w[15]}}, sin_w};
						qb_q <= {2'b00, wdepth_q};
					end else begin
						ma_q <= {{19{in_data.sample_in[15]}}, in_data.sample_in};
						qa_q <= gain_q;
						mb_q <= {{17{noise_next[15]}}, noise_next};
						qb_q <= {2'b00, nlevel_q};
					end
					acca_q <= '0;
					accb_q <= '0;
				end
			end
			ST_GAIN, ST_MUL: begin
				acca_q <= acca_q + (qa_q[0] ? ma_q : 35'h0);
				accb_q <= accb_q + (qb_q[0] ? mb_q : 33'h0);
				ma_q <= ma_q << 1;
				mb_q <= mb_q << 1;
				qa_q <= qa_q >> 1;
				qb_q <= qb_q >> 1;
			end
			ST_GSUM: begin
				ma_q <= {{19{x_q[15]}}, x_q};
				qa_q <= gain_new;
				mb_q <= {{17{noise_q[15]}}, noise_q};
				qb_q <= {2'b00, nlevel_q};
				acca_q <= '0;
				accb_q <= '0;
			end
			ST_DONE: begin
				if (out_free) begin
					if (clip_hi)
						out_q.sample_out <= 16'sh7FFF;
					else if (clip_lo)
						out_q.sample_out <= 16'sh8000;
					else
						out_q.sample_out <= y[15:0];
					out_q.clipped <= clip_hi || clip_lo;
					out_q.block_end_out <= bend_q;
				end
			end
			default: begin
			end
		endcase
	end

	a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		lfsr_q != 32'h0)
		else $error("noise generator reached the all-zero state");

	a_accept_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_GAIN || state_q == ST_MUL))
		else $error("accepted sample did not start a multiply pass");

	a_gsum_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_GSUM |=> state_q == ST_MUL && iter_q == '0)
		else $error("gain sum not followed by a fresh multiply pass");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result appeared without finishing a sample");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
module tb_top;
	import twfn_pkg::*;

	localparam longint SIN_A = 102944;
	localparam longint SIN_B = 42334;
	localparam longint SIN_C = 5223;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic [3:0] r_count;
	logic [31:0] r_fl_step;
	logic [31:0] r_wo_step;
	logic [15:0] r_fl_depth;
	logic [15:0] r_wo_depth;
	logic [15:0] r_noise_lvl;

	logic [31:0] fl_phase;
	logic [31:0] wo_phase;
	int frame_pos;
	logic [17:0] cur_gain;
	logic [31:0] noise_reg;

	out_item_t awaited[$];
	out_item_t head;
	int errors = 0;
	int burst_left = 0;
	int gap_max = 5;
	int stall_pct = 30;
	int stall_left = 0;
	bit stall_now = 1'b0;
	bit valid_on = 1'b0;

	tape_wow_flutter_noise dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint sine_at(input logic [31:0] phase);
		logic [SINE_IDX_W-1:0] idx;
		logic [1:0] quadrant;
		longint t, t2, poly, s;
		idx = phase[PHASE_W-1 -: SINE_IDX_W];
		quadrant = idx[SINE_IDX_W-1 -: 2];
		t = longint'(idx[SINE_IDX_W-3:0]) * (262144 / SINE_DEPTH);
		if (quadrant[0])
			t = 65536 - t;
		t2 = (t * t) >>> 16;
		poly = SIN_B - ((t2 * SIN_C) >>> 16);
		poly = SIN_A - ((t2 * poly) >>> 16);
		s = ((t * poly) >>> 16) >>> 1;
		if (s > 32767)
			s = 32767;
		return quadrant[1] ? -s : s;
	endfunction

	function automatic out_item_t modulate_sample(input in_item_t item);
		out_item_t res;
		longint g, m, n, y;
		int eff;
		eff = (r_count == 0) ? 1 : (r_count > MAX_CHANNELS) ? MAX_CHANNELS : int'(r_count);
		if (frame_pos == 0) begin
			g = longint'(UNITY_GAIN)
				+ ((sine_at(fl_phase) * longint'(r_fl_depth)) >>> 15)
				+ ((sine_at(wo_phase) * longint'(r_wo_depth)) >>> 15);
			if (g < 0)
				g = 0;
			if (g > longint'(GAIN_MAX))
				g = longint'(GAIN_MAX);
			cur_gain = g[17:0];
		end
		m = (longint'($signed(item.sample_in)) * longint'(cur_gain) + 32768) >>> 16;
		if (noise_reg[0])
			noise_reg = (noise_reg >> 1) ^ LFSR_TAPS;
		else
			noise_reg = noise_reg >> 1;
		n = longint'(noise_reg[31:16]) - 32768;
		y = m + ((n * longint'(r_noise_lvl)) >>> 16);
		res.clipped = 1'b0;
		if (y > 32767) begin
			y = 32767;
			res.clipped = 1'b1;
		end
		if (y < -32768) begin
			y = -32768;
			res.clipped = 1'b1;
		end
		if (frame_pos + 1 >= eff) begin
			fl_phase = fl_phase + r_fl_step;
			wo_phase = wo_phase + r_wo_step;
			frame_pos = 0;
		end else begin
			frame_pos++;
		end
		res.sample_out = y[15:0];
		res.block_end_out = item.block_end;
		return res;
	endfunction

	function automatic logic [31:0] pick_value(input logic [31:0] top);
		case ($urandom_range(0, 4))
			0: return '0;
			1: return top;
			2: return $urandom_range(0, top >> 6);
			default: return $urandom_range(0, top);
		endcase
	endfunction

	task automatic send_sample(input logic signed [15:0] s, input logic be);
		in_item_t item;
		int gap;
		item.sample_in = s;
		item.block_end = be;
		in_valid <= 1'b1;
		valid_on = 1'b1;
		in_data <= item;
		do @(posedge clk); while (in_stall);
		awaited.push_back(modulate_sample(item));
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
			if (gap > 0) begin
				in_valid <= 1'b0;
				valid_on = 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_CHANNEL_COUNT: r_count = val[3:0];
			REG_FLUTTER_STEP: r_fl_step = val;
			REG_WOW_STEP: r_wo_step = val;
			REG_FLUTTER_DEPTH: r_fl_depth = val[15:0];
			REG_WOW_DEPTH: r_wo_depth = val[15:0];
			REG_NOISE_LEVEL: r_noise_lvl = val[15:0];
			REG_NOISE_SEED: noise_reg = (val == 0) ? 32'd1 : val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic wait_idle();
		if (valid_on) begin
			in_valid <= 1'b0;
			valid_on = 1'b0;
		end
		while (awaited.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_reset_defaults();
		send_sample(16'sh7FFF, 1'b0);
		send_sample(-16'sh8000, 1'b0);
		send_sample(16'sh0000, 1'b1);
		send_sample(-16'sh0001, 1'b0);
		send_sample(16'sh0001, 1'b1);
		send_sample(16'sh3039, 1'b0);
	endtask

	task automatic test_channel_count();
		wait_idle();
		write_reg(REG_CHANNEL_COUNT, 32'd8);
		repeat (5) send_sample(16'($urandom), 1'($urandom_range(0, 1)));
		// Lowering the count while inside a frame closes that frame on the next sample.
		wait_idle();
		write_reg(REG_CHANNEL_COUNT, 32'd3);
		repeat (3) send_sample(16'($urandom), 1'b0);
		wait_idle();
		write_reg(REG_CHANNEL_COUNT, 32'd0);
		repeat (2) send_sample(16'($urandom), 1'b1);
		wait_idle();
		write_reg(REG_CHANNEL_COUNT, 32'd15);
		repeat (2) send_sample(16'($urandom), 1'b0);
	endtask

	task automatic test_gain_limits();
		wait_idle();
		write_reg(REG_CHANNEL_COUNT, 32'd1);
		write_reg(REG_FLUTTER_STEP, 32'hC000_0000);
		write_reg(REG_WOW_STEP, 32'hC000_0000);
		write_reg(REG_FLUTTER_DEPTH, 32'hFFFF);
		write_reg(REG_WOW_DEPTH, 32'hFFFF);
		write_reg(REG_NOISE_LEVEL, 32'd0);
		send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sh7FFF, 1'b0);
		send_sample(-16'sh8000, 1'b1);
		send_sample(-16'sh8000, 1'b0);
	endtask

	task automatic test_noise_seed();
		wait_idle();
		write_reg(REG_FLUTTER_DEPTH, 32'd0);
		write_reg(REG_WOW_DEPTH, 32'd0);
		write_reg(REG_NOISE_LEVEL, 32'hFFFF);
		write_reg(REG_NOISE_SEED, 32'd0);
		send_sample(16'sh7FFF, 1'b0);
		send_sample(-16'sh8000, 1'b0);
		wait_idle();
		write_reg(REG_NOISE_SEED, 32'hFFFF_FFFF);
		send_sample(16'sh0000, 1'b1);
		send_sample(16'sh7FF0, 1'b0);
	endtask

	task automatic test_random_traffic(input int n_items, input bit calm);
		logic signed [15:0] s;
		wait_idle();
		write_reg(REG_CHANNEL_COUNT,
			($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8));
		write_reg(REG_FLUTTER_STEP, pick_value(32'hFFFF_FFFF));
		write_reg(REG_WOW_STEP, pick_value(32'hFFFF_FFFF));
		write_reg(REG_FLUTTER_DEPTH, pick_value(32'hFFFF));
		write_reg(REG_WOW_DEPTH, pick_value(32'hFFFF));
		write_reg(REG_NOISE_LEVEL, pick_value(32'hFFFF));
		write_reg(REG_NOISE_SEED, pick_value(32'hFFFF_FFFF));
		if (calm) begin
			gap_max = 0;
			stall_pct = 0;
		end else begin
			case ($urandom_range(0, 2))
				0: gap_max = 2;
				1: gap_max = 15;
				default: gap_max = 45;
			endcase
			stall_pct = $urandom_range(10, 70);
		end
		burst_left = 0;
		repeat (n_items) begin
			case ($urandom_range(0, 5))
				0: s = 16'sh7FFF;
				1: s = -16'sh8000;
				2: s = $signed(16'($urandom_range(0, 511))) - 16'sd256;
				default: s = 16'($urandom);
			endcase
			send_sample(s, $urandom_range(0, 7) == 0);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (awaited.size() == 0) begin
				$display("%0t: result with none expected, got %p", $time, out_data);
				errors++;
			end else begin
				head = awaited.pop_front();
				if (out_data.sample_out !== head.sample_out) begin
					$display("%0t: sample_out expected %0d, got %0d", $time,
						head.sample_out, out_data.sample_out);
					errors++;
				end
				if (out_data.clipped !== head.clipped) begin
					$display("%0t: clipped expected %0b, got %0b", $time,
						head.clipped, out_data.clipped);
					errors++;
				end
				if (out_data.block_end_out !== head.block_end_out) begin
					$display("%0t: block_end_out expected %0b, got %0b", $time,
						head.block_end_out, out_data.block_end_out);
					errors++;
				end
			end
		end
		if (stall_left == 0) begin
			stall_now = ($urandom_range(0, 99) < stall_pct);
			stall_left = stall_now ? $urandom_range(1, 12) : $urandom_range(1, 30);
		end
		stall_left--;
		out_stall <= stall_now;
	end

	initial begin
		r_count = 4'd1;
		r_fl_step = 32'd486958;
		r_wo_step = 32'd48696;
		r_fl_depth = 16'd197;
		r_wo_depth = 16'd131;
		r_noise_lvl = 16'd328;
		fl_phase = '0;
		wo_phase = '0;
		frame_pos = 0;
		cur_gain = UNITY_GAIN;
		noise_reg = 32'd1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_channel_count();
		test_gain_limits();
		test_noise_seed();
		for (int k = 0; k < 6; k++)
			test_random_traffic(171, k == 0);
		wait_idle();
		repeat (40) @(posedge clk);
		if (errors == 0 && awaited.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		#8000000;
		$display("tb_top NOT OK");
		$finish;
	end

endmodule
